// ===== rtl/assert_macros.svh =====
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is asserted.
`define SPT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is asserted.
`define SPT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/spt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package spt_pkg;
    localparam int TABLE_ENTRIES = 256;
    localparam int ADDR_W        = 48;
    localparam int STRIDE_W      = 32;
    localparam int BLK_W         = 4;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int RANK_W        = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
    localparam logic [BLK_W-1:0] BLK_LOG2_RST = BLK_W'(6);

    typedef struct packed {
        logic [ADDR_W-1:0]   pc;
        logic [ADDR_W-1:0]   last_addr;
        logic [STRIDE_W-1:0] stride;
        logic [RANK_W-1:0]   rank;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SEARCH = 5'b00010,
        ST_DECIDE = 5'b00100,
        ST_UPDATE = 5'b01000,
        ST_FINISH = 5'b10000
    } t_state;
endpackage
`default_nettype wire

// ===== rtl/spt_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module spt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/stride_prefetch_table_unit.sv =====
// Hit access: taken while idle, no table change, no result.
// Miss with N filled entries: a read sweep finds the pc and the LRU victim, then a
// read-modify-write sweep re-ranks and updates, both via the single table RAM read port.
// The next transfer is taken once idle again; a stalled earlier result adds its stall.
// Reset (synchronous, active low): table empty (fill count 0), block size log2 = 6.
`timescale 1ns / 1ps
`default_nettype none
module stride_prefetch_table_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [spt_pkg::BLK_W-1:0]     i_cfg_wdata,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [spt_pkg::ADDR_W-1:0]    i_pc,
    input  wire logic [spt_pkg::ADDR_W-1:0]    i_mem_addr,
    input  wire logic                          i_is_miss,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic      [spt_pkg::ADDR_W-1:0]    o_prefetch_addr
);
    import spt_pkg::*;

    t_state             r_state, n_state;
    logic [BLK_W-1:0]   r_blk_log2;
    logic [CNT_W-1:0]   r_count;
    logic [ADDR_W-1:0]  r_pc, r_addr;
    logic [CNT_W-1:0]   r_iss;
    logic               r_pend;
    logic [IDX_W-1:0]   r_pidx;
    logic               r_hit;
    logic [IDX_W-1:0]   r_mslot, r_victim, r_slot;
    logic [RANK_W-1:0]  r_mrank;
    logic [RANK_W:0]    r_old_rank;
    logic               r_res_hit;
    logic [ADDR_W-1:0]  r_res;
    logic               r_o_valid;
    logic [ADDR_W-1:0]  r_o_addr;

    logic               in_xfer, out_xfer, sweep, issue, sweep_done;
    t_entry             rd_entry, wr_entry;
    logic               wr_en;
    logic [ADDR_W-1:0]  cur_last;
    logic [STRIDE_W-1:0] cur_stride, new_stride;

    assign in_xfer    = i_in_valid && !o_in_stall;
    assign out_xfer   = r_o_valid && !i_out_stall;
    assign o_in_stall = (r_state != ST_IDLE);
    assign o_out_valid     = r_o_valid;
    assign o_prefetch_addr = r_o_addr;

    assign sweep      = (r_state == ST_SEARCH) || (r_state == ST_UPDATE);
    assign issue      = sweep && (r_iss < r_count);
    assign sweep_done = sweep && !issue && !r_pend;

    spt_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_table (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_pidx),
        .i_wdata (wr_entry),
        .i_raddr (r_iss[IDX_W-1:0]),
        .o_rdata (rd_entry)
    );

    // merge the returned entry: target slot takes the new address, lower-ranked others age
    always_comb begin
        cur_last   = r_hit ? rd_entry.last_addr : '0;
        cur_stride = r_hit ? rd_entry.stride : '0;
        new_stride = r_addr[STRIDE_W-1:0] - cur_last[STRIDE_W-1:0];
        wr_entry   = rd_entry;
        if (r_pidx == r_slot) begin
            wr_entry.pc        = r_pc;
            wr_entry.last_addr = r_addr;
            wr_entry.stride    = new_stride;
            wr_entry.rank      = '0;
        end else if ({1'b0, rd_entry.rank} < r_old_rank) begin
            wr_entry.rank = rd_entry.rank + 1'b1;
        end
        wr_en = (r_state == ST_UPDATE) && r_pend;
    end

    // state sequencing
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (in_xfer && i_is_miss) n_state = ST_SEARCH;
            ST_SEARCH: if (sweep_done) n_state = ST_DECIDE;
            ST_DECIDE: n_state = ST_UPDATE;
            ST_UPDATE: if (sweep_done) n_state = ST_FINISH;
            ST_FINISH: if (!r_res_hit || !r_o_valid || !i_out_stall) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_blk_log2 <= BLK_LOG2_RST;
            r_count    <= '0;
            r_pend     <= 1'b0;
            r_iss      <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_blk_log2 <= i_cfg_wdata;
            end
            r_pend <= issue;
            if (issue) begin
                r_iss <= r_iss + 1'b1;
            end else if (sweep_done) begin
                r_iss <= '0;
            end
            if (r_state == ST_DECIDE && !r_hit && r_count < CNT_W'(TABLE_ENTRIES)) begin
                r_count <= r_count + 1'b1;
            end
            if (r_state == ST_FINISH && r_res_hit && (!r_o_valid || !i_out_stall)) begin
                r_o_valid <= 1'b1;
            end else if (out_xfer) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // payload: capture item, track lookup, hold result
    always_ff @(posedge i_clk) begin
        r_pidx <= r_iss[IDX_W-1:0];
        if (in_xfer) begin
            r_pc   <= i_pc;
            r_addr <= i_mem_addr & ({ADDR_W{1'b1}} << r_blk_log2);
            r_hit  <= 1'b0;
        end
        if (r_state == ST_SEARCH && r_pend) begin
            if (rd_entry.pc == r_pc) begin
                r_hit   <= 1'b1;
                r_mslot <= r_pidx;
                r_mrank <= rd_entry.rank;
            end
            if (rd_entry.rank == RANK_W'(TABLE_ENTRIES - 1)) begin
                r_victim <= r_pidx;
            end
        end
        if (r_state == ST_DECIDE) begin
            if (r_hit) begin
                r_slot     <= r_mslot;
                r_old_rank <= {1'b0, r_mrank};
            end else if (r_count < CNT_W'(TABLE_ENTRIES)) begin
                r_slot     <= r_count[IDX_W-1:0];
                r_old_rank <= (RANK_W+1)'(TABLE_ENTRIES);
            end else begin
                r_slot     <= r_victim;
                r_old_rank <= (RANK_W+1)'(TABLE_ENTRIES - 1);
            end
        end
        if (wr_en && r_pidx == r_slot) begin
            r_res_hit <= (new_stride == cur_stride);
            r_res     <= r_addr + {{(ADDR_W-STRIDE_W){cur_stride[STRIDE_W-1]}}, cur_stride};
        end
        if (r_state == ST_FINISH && r_res_hit && (!r_o_valid || !i_out_stall)) begin
            r_o_addr <= r_res;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/spt_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module spt_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_in_valid,
    input wire logic                       o_in_stall,
    input wire logic                       i_is_miss,
    input wire logic                       o_out_valid,
    input wire logic                       i_out_stall,
    input wire logic [spt_pkg::ADDR_W-1:0] o_prefetch_addr
);
    import spt_pkg::*;

    logic hit_xfer, miss_xfer;
    assign hit_xfer  = i_in_valid && !o_in_stall && !i_is_miss;
    assign miss_xfer = i_in_valid && !o_in_stall && i_is_miss;

    // a stalled result holds its address
    `SPT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_prefetch_addr), "stalled result changed")
    // a hit transfer leaves the block ready
    `SPT_ASSERT_NEXT(a_hit_ready, i_clk, i_rst_n, hit_xfer, !o_in_stall, "hit did not return to ready")
    // a miss transfer starts a table walk
    `SPT_ASSERT_NEXT(a_miss_busy, i_clk, i_rst_n, miss_xfer, o_in_stall, "miss did not start a walk")
    // a new result appears only at the end of a walk
    `SPT_ASSERT_IMPL(a_res_walk, i_clk, i_rst_n, $rose(o_out_valid), $past(o_in_stall), "result without walk")
endmodule

bind stride_prefetch_table_unit spt_checker u_spt_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .i_is_miss       (i_is_miss),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_prefetch_addr (o_prefetch_addr)
);
`default_nettype wire

// ===== bench/tb_stride_prefetch_table_unit.sv =====
`timescale 1ns / 1ps
module tb_stride_prefetch_table_unit;
    import spt_pkg::*;

    localparam int GAP_LIMIT = 200000;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [BLK_W-1:0]    i_cfg_wdata;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [ADDR_W-1:0]   i_pc;
    logic [ADDR_W-1:0]   i_mem_addr;
    logic                i_is_miss;
    logic                o_out_valid;
    logic                i_out_stall;
    logic [ADDR_W-1:0]   o_prefetch_addr;

    stride_prefetch_table_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_pc(i_pc), .i_mem_addr(i_mem_addr), .i_is_miss(i_is_miss),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_prefetch_addr(o_prefetch_addr)
    );

    // Shadow copy of the stride table
    logic              tbl_valid [TABLE_ENTRIES];
    logic [ADDR_W-1:0] tbl_pc    [TABLE_ENTRIES];
    logic [ADDR_W-1:0] tbl_last  [TABLE_ENTRIES];
    logic [31:0]       tbl_stride[TABLE_ENTRIES];
    int                tbl_rank  [TABLE_ENTRIES];
    int                tbl_fill;
    logic [BLK_W-1:0]  blk_log2;

    logic [ADDR_W-1:0] pending_prefetch[$];
    int  fail_cnt = 0;
    int  send_idle_pct;
    int  recv_idle_pct;
    int  quiet_cycles = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Move slot to the front of the LRU order
    task automatic make_recent(input int slot, input int old_rank);
        for (int i = 0; i < TABLE_ENTRIES; i++)
            if (tbl_valid[i] && i != slot && tbl_rank[i] < old_rank)
                tbl_rank[i]++;
        tbl_rank[slot] = 0;
    endtask

    // Predict the prefetch caused by one accepted access
    task automatic predict_prefetch(input logic [ADDR_W-1:0] pc,
                                    input logic [ADDR_W-1:0] addr, input logic miss);
        int slot;
        logic [ADDR_W-1:0] aligned;
        logic [31:0] stride;
        slot = -1;
        if (!miss) return;
        aligned = addr & ~((48'd1 << blk_log2) - 48'd1);
        for (int i = 0; i < TABLE_ENTRIES; i++)
            if (slot < 0 && tbl_valid[i] && tbl_pc[i] == pc) slot = i;
        if (slot >= 0) begin
            make_recent(slot, tbl_rank[slot]);
        end else begin
            if (tbl_fill < TABLE_ENTRIES) begin
                slot = tbl_fill;
                tbl_valid[slot] = 1'b1;
                tbl_fill++;
                make_recent(slot, TABLE_ENTRIES);
            end else begin
                slot = 0;
                for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
                    if (tbl_rank[i] == TABLE_ENTRIES - 1) slot = i;
                make_recent(slot, TABLE_ENTRIES - 1);
            end
            tbl_pc[slot] = pc;
            tbl_last[slot] = '0;
            tbl_stride[slot] = '0;
        end
        stride = 32'(aligned - tbl_last[slot]);
        if (stride == tbl_stride[slot])
            pending_prefetch.push_back(aligned + {{16{stride[31]}}, stride});
        tbl_stride[slot] = stride;
        tbl_last[slot] = aligned;
    endtask

    // Send one access and hold it until the transfer
    task automatic send_access(input logic [ADDR_W-1:0] pc,
                               input logic [ADDR_W-1:0] addr, input logic miss);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_pc <= pc;
        i_mem_addr <= addr;
        i_is_miss <= miss;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_prefetch(pc, addr, miss);
    endtask

    // Wait for all prefetches, then let a trailing miss finish
    task automatic drain;
        i_in_valid <= 1'b0;
        while (pending_prefetch.size() != 0) @(posedge i_clk);
        repeat (2 * TABLE_ENTRIES + 20) @(posedge i_clk);
    endtask

    task automatic write_blk(input logic [BLK_W-1:0] val);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        blk_log2 = val;
    endtask

    function automatic logic [ADDR_W-1:0] rand48;
        return {16'($urandom), $urandom};
    endfunction

    // Receiver stall and result checking
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_prefetch.size() == 0) begin
                    $display("%0t: unexpected prefetch actual=%h", $time, o_prefetch_addr);
                    fail_cnt++;
                end else begin
                    if (pending_prefetch[0] !== o_prefetch_addr) begin
                        $display("%0t: prefetch_addr expected=%h actual=%h",
                                 $time, pending_prefetch[0], o_prefetch_addr);
                        fail_cnt++;
                    end
                    void'(pending_prefetch.pop_front());
                end
            end
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= GAP_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic test_directed;
        send_access(48'h1, 48'h0, 1'b1);            // fresh entry at address 0
        send_access(48'h1, 48'h0, 1'b0);            // hit
        send_access(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1);
        send_access(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1);
        send_access(48'h2, 48'h1000, 1'b1);
        send_access(48'h2, 48'h1040, 1'b1);
        send_access(48'h2, 48'h1080, 1'b1);
        send_access(48'h2, 48'h1040, 1'b1);         // negative stride
        send_access(48'h2, 48'h1000, 1'b1);
        send_access(48'h3, 48'h8000_0000_0000, 1'b1); // stride wraps 32 bits
        send_access(48'h3, 48'h0, 1'b1);
        send_access(48'h3, 48'h0, 1'b1);
        send_access(48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, 1'b1);
        send_access(48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 1'b0);
    endtask

    // Fill the table past capacity so LRU eviction happens
    task automatic test_eviction;
        for (int i = 0; i < TABLE_ENTRIES + 20; i++)
            send_access(48'h10000 + 48'(i), 48'(i) << 8, 1'b1);
        for (int i = 0; i < 40; i++)
            send_access(48'h10000 + 48'($urandom_range(TABLE_ENTRIES + 19)), rand48(), 1'b1);
    endtask

    task automatic test_blk_sizes;
        logic [BLK_W-1:0] sizes[5] = '{4'd0, 4'd12, 4'd15, 4'd13, 4'd3};
        foreach (sizes[k]) begin
            write_blk(sizes[k]);
            for (int i = 0; i < 12; i++)
                send_access(48'h7700 + 48'(i % 3), 48'h100 * 48'(i) + 48'($urandom_range(255)),
                            1'b1);
        end
        write_blk(4'd6);
    endtask

    // Mostly small pc sets walking with steady strides, some noise
    task automatic test_random(input int n);
        logic [ADDR_W-1:0] base [8];
        logic [ADDR_W-1:0] step [8];
        int k;
        for (int j = 0; j < 8; j++) begin
            base[j] = rand48();
            step[j] = 48'($signed(32'($urandom_range(16) - 8))) << blk_log2;
        end
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(7);
            if ($urandom_range(9) < 7) begin
                send_access(48'hC000 + 48'(k), base[k], $urandom_range(9) != 0);
                base[k] = base[k] + step[k];
            end else begin
                send_access($urandom_range(3) == 0 ? rand48() : 48'(k),
                            rand48(), 1'($urandom_range(1)));
            end
        end
    endtask

    initial begin
        send_idle_pct = 14;
        recv_idle_pct = 55;
        blk_log2 = BLK_LOG2_RST;
        tbl_fill = 0;
        for (int i = 0; i < TABLE_ENTRIES; i++) tbl_valid[i] = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        i_in_valid = 1'b0;
        i_pc = '0;
        i_mem_addr = '0;
        i_is_miss = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_eviction();
        test_blk_sizes();
        test_random(400);
        drain();                                    // sender holds off until empty
        send_idle_pct = 55;
        recv_idle_pct = 14;
        test_random(400);
        write_blk(4'd4);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(400);
        write_blk(4'd6);
        test_random(200);
        drain();

        if (fail_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
